// File: rtl/sh_ctp_pkg.sv
// Shared constants and codes for the cosine transfer projection unit.
package sh_ctp_pkg;

  // Default sizes handed to the top level parameters.
  localparam int MAX_SAMPLES_DEF = 1024;
  localparam int NUM_COEFFS_DEF  = 9;

  // Field widths of the input and result items.
  localparam int CMD_W    = 2;
  localparam int SIDX_W   = 10;
  localparam int CIDX_W   = 4;
  localparam int VAL_W    = 16;
  localparam int RIDX_W   = 4;
  localparam int RES_W    = 32;

  // Configuration register widths and reset values.
  localparam int SIU_W    = 11;
  localparam int WGT_W    = 24;
  localparam logic [SIU_W-1:0] SIU_RESET = 11'd1024;
  localparam logic [WGT_W-1:0] WGT_RESET = 24'd12868;

  // Configuration port.
  localparam int APB_AW = 3;
  localparam int APB_DW = 32;
  localparam logic [0:0] REG_SAMPLES_IN_USE = 1'b0;
  localparam logic [0:0] REG_SAMPLE_WEIGHT  = 1'b1;

  // Command codes.
  localparam logic [CMD_W-1:0] CMD_LOAD_DIR   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_LOAD_COEFF = 2'd1;
  localparam logic [CMD_W-1:0] CMD_COMPUTE    = 2'd2;

  // Shared multiplier operand widths and limb size for the final scaling.
  localparam int MUL_AW = 19;
  localparam int MUL_BW = 25;
  localparam int PROD_W = MUL_AW + MUL_BW;
  localparam int LIMB_W = 18;

endpackage

// File: rtl/sh_ctp_in_if.sv
// Input channel of the cosine transfer projection unit: loads and compute items.
interface sh_ctp_in_if;
  logic                                     valid;
  logic                                     ready;
  logic        [sh_ctp_pkg::CMD_W-1:0]      command;
  logic        [sh_ctp_pkg::SIDX_W-1:0]     sample_index;
  logic        [sh_ctp_pkg::CIDX_W-1:0]     coeff_index;
  logic signed [sh_ctp_pkg::VAL_W-1:0]      coeff_value;
  logic signed [sh_ctp_pkg::VAL_W-1:0]      dir_x;
  logic signed [sh_ctp_pkg::VAL_W-1:0]      dir_y;
  logic signed [sh_ctp_pkg::VAL_W-1:0]      dir_z;
  logic signed [sh_ctp_pkg::VAL_W-1:0]      normal_x;
  logic signed [sh_ctp_pkg::VAL_W-1:0]      normal_y;
  logic signed [sh_ctp_pkg::VAL_W-1:0]      normal_z;

  modport source (
    output valid, command, sample_index, coeff_index, coeff_value,
           dir_x, dir_y, dir_z, normal_x, normal_y, normal_z,
    input  ready
  );
  modport sink (
    input  valid, command, sample_index, coeff_index, coeff_value,
           dir_x, dir_y, dir_z, normal_x, normal_y, normal_z,
    output ready
  );
endinterface

// File: rtl/sh_ctp_out_if.sv
// Result channel of the cosine transfer projection unit: one item per coefficient.
interface sh_ctp_out_if;
  logic                                 valid;
  logic                                 ready;
  logic        [sh_ctp_pkg::RIDX_W-1:0] result_index;
  logic signed [sh_ctp_pkg::RES_W-1:0]  transfer_value;
  logic                                 last;

  modport source (output valid, result_index, transfer_value, last, input ready);
  modport sink   (input valid, result_index, transfer_value, last, output ready);
endinterface

// File: rtl/sh_cosine_transfer_projection_unit.sv
// A load item (direction or coefficient) is written into its memory. A compute item walks
// the loaded samples through one shared 19x25 signed multiplier: each sample gets its
// three-term dot product and, when the dot product is positive, a multiply-accumulate
// for every coefficient. After the walk each coefficient is scaled by the sample weight
// in LIMBS partial products on the same multiplier and handed to the output register.
// The input is not ready while a compute is running.
module sh_cosine_transfer_projection_unit #(
  parameter int MAX_SAMPLES = sh_ctp_pkg::MAX_SAMPLES_DEF,
  parameter int NUM_COEFFS  = sh_ctp_pkg::NUM_COEFFS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  sh_ctp_in_if.sink                         in_ch,
  sh_ctp_out_if.source                      out_ch,
  input  logic                              cfg_psel,
  input  logic                              cfg_penable,
  input  logic                              cfg_pwrite,
  input  logic [sh_ctp_pkg::APB_AW-1:0]     cfg_paddr,
  input  logic [sh_ctp_pkg::APB_DW-1:0]     cfg_pwdata,
  output logic [sh_ctp_pkg::APB_DW-1:0]     cfg_prdata,
  output logic                              cfg_pready
);

  localparam int ADDR_W   = $clog2(MAX_SAMPLES);
  localparam int CNT_W    = $clog2(MAX_SAMPLES + 1);
  localparam int COEF_D   = MAX_SAMPLES * NUM_COEFFS;
  localparam int COEF_AW  = $clog2(COEF_D);
  localparam int JW       = (NUM_COEFFS > 1) ? $clog2(NUM_COEFFS) : 1;
  localparam int TAG_W    = $clog2(NUM_COEFFS + 3);
  localparam int ACC_W    = 35 + $clog2(MAX_SAMPLES);
  localparam int LIMBS    = (ACC_W + sh_ctp_pkg::LIMB_W - 1) / sh_ctp_pkg::LIMB_W;
  localparam int PAD_W    = LIMBS * sh_ctp_pkg::LIMB_W;
  localparam int FIN_W    = PAD_W + sh_ctp_pkg::MUL_BW;
  localparam int DOT_W    = 34;
  localparam int H_W      = 18;
  localparam int VW       = sh_ctp_pkg::VAL_W;

  localparam logic signed [FIN_W-1:0] RND    = FIN_W'(64'sd8589934592);
  localparam logic signed [FIN_W-1:0] SAT_HI = FIN_W'(64'sd2147483647);
  localparam logic signed [FIN_W-1:0] SAT_LO = FIN_W'(-64'sd2147483648);

  typedef enum logic [2:0] {
    ST_IDLE, ST_DOT, ST_DOTW, ST_MAC, ST_DRAIN, ST_FIN, ST_FOUT
  } state_t;

  typedef enum logic [1:0] {K_DOT, K_ACC, K_FIN} kind_t;

  // Configuration registers.
  logic [sh_ctp_pkg::SIU_W-1:0] siu_r;
  logic [sh_ctp_pkg::WGT_W-1:0] wgt_r;
  logic                         cfg_wr;

  // Sequencer.
  state_t                       state_r;
  logic [1:0]                   k_r;
  logic [CNT_W-1:0]             samp_r;
  logic [CNT_W-1:0]             n_r;
  logic [COEF_AW-1:0]           ca_r;
  logic [JW-1:0]                j_r;
  logic [JW-1:0]                fj_r;
  logic [TAG_W-1:0]             l_r;
  logic signed [VW-1:0]         nx_r, ny_r, nz_r;
  logic [H_W-1:0]               h_r;

  // Operand stage and product stage of the shared multiplier.
  logic                         iss_v;
  kind_t                        iss_kind;
  logic [TAG_W-1:0]             iss_idx;
  logic                         b_v_r, c_v_r;
  kind_t                        b_kind_r, c_kind_r;
  logic [TAG_W-1:0]             b_idx_r, c_idx_r;
  logic signed [sh_ctp_pkg::MUL_AW-1:0] mul_a;
  logic signed [sh_ctp_pkg::MUL_BW-1:0] mul_b;
  logic signed [sh_ctp_pkg::PROD_W-1:0] prod_r;
  logic                         pipe_empty;

  // Accumulation registers.
  logic signed [DOT_W-1:0]      dot_r;
  logic signed [ACC_W-1:0]      acc_r [NUM_COEFFS];
  logic [JW-1:0]                acc_sel;
  logic signed [ACC_W-1:0]      acc_rd;
  logic signed [PAD_W-1:0]      acc_pad;
  logic [sh_ctp_pkg::LIMB_W-1:0] limb;
  logic signed [FIN_W-1:0]      fin_r;
  logic signed [FIN_W-1:0]      fin_sh;
  logic signed [sh_ctp_pkg::RES_W-1:0] sat_val;

  // Memories.
  logic [3*VW-1:0]              dir_mem [MAX_SAMPLES];
  logic signed [VW-1:0]         coef_mem [COEF_D];
  logic [3*VW-1:0]              dir_r;
  logic signed [VW-1:0]         coef_r;
  logic                         dir_rd;

  // Output register.
  logic                         out_valid_r;
  logic [sh_ctp_pkg::RIDX_W-1:0] out_index_r;
  logic signed [sh_ctp_pkg::RES_W-1:0] out_value_r;
  logic                         out_last_r;
  logic                         out_free;

  logic                         in_fire;
  logic                         sidx_ok;
  logic                         cidx_ok;
  logic [COEF_AW-1:0]           load_ca;
  logic                         dot_pos;
  logic [H_W-1:0]               h_new;
  logic                         samp_done;
  logic [CNT_W-1:0]             n_new;

  // ---------------------------------------------------------------- config port
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;

  always_comb begin
    case (cfg_paddr[2:2])
      sh_ctp_pkg::REG_SAMPLES_IN_USE: cfg_prdata = sh_ctp_pkg::APB_DW'(siu_r);
      sh_ctp_pkg::REG_SAMPLE_WEIGHT:  cfg_prdata = sh_ctp_pkg::APB_DW'(wgt_r);
      default:                        cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      siu_r <= sh_ctp_pkg::SIU_RESET;
      wgt_r <= sh_ctp_pkg::WGT_RESET;
    end else if (cfg_wr) begin
      case (cfg_paddr[2:2])
        sh_ctp_pkg::REG_SAMPLES_IN_USE: siu_r <= cfg_pwdata[sh_ctp_pkg::SIU_W-1:0];
        sh_ctp_pkg::REG_SAMPLE_WEIGHT:  wgt_r <= cfg_pwdata[sh_ctp_pkg::WGT_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- input side
  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign sidx_ok     = 32'(in_ch.sample_index) < MAX_SAMPLES;
  assign cidx_ok     = 32'(in_ch.coeff_index) < NUM_COEFFS;
  assign load_ca     = COEF_AW'(32'(in_ch.sample_index) * NUM_COEFFS + 32'(in_ch.coeff_index));
  assign n_new       = (32'(siu_r) > MAX_SAMPLES) ? CNT_W'(MAX_SAMPLES) : CNT_W'(siu_r);

  always_ff @(posedge clk) begin
    if (in_fire && in_ch.command == sh_ctp_pkg::CMD_LOAD_DIR && sidx_ok) begin
      dir_mem[in_ch.sample_index[ADDR_W-1:0]] <= {in_ch.dir_x, in_ch.dir_y, in_ch.dir_z};
    end
    if (dir_rd) begin
      dir_r <= dir_mem[samp_r[ADDR_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && in_ch.command == sh_ctp_pkg::CMD_LOAD_COEFF && sidx_ok && cidx_ok) begin
      coef_mem[load_ca] <= in_ch.coeff_value;
    end
    if (state_r == ST_MAC) begin
      coef_r <= coef_mem[ca_r];
    end
  end

  // ---------------------------------------------------------------- issue
  always_comb begin
    iss_v    = 1'b0;
    iss_kind = K_DOT;
    iss_idx  = '0;
    dir_rd   = 1'b0;
    case (state_r)
      ST_DOT: begin
        iss_v   = 1'b1;
        iss_idx = TAG_W'(k_r);
        dir_rd  = (k_r == 2'd0);
      end
      ST_MAC: begin
        iss_v    = 1'b1;
        iss_kind = K_ACC;
        iss_idx  = TAG_W'(j_r);
      end
      ST_FIN: begin
        iss_v    = 1'b1;
        iss_kind = K_FIN;
        iss_idx  = l_r;
      end
      default: ;
    endcase
  end

  assign pipe_empty = !b_v_r && !c_v_r;
  assign out_free   = !out_valid_r || out_ch.ready;

  // A sample counts when its dot product is strictly positive.
  assign dot_pos   = !dot_r[DOT_W-1] && (dot_r != '0);
  assign h_new     = H_W'((dot_r + DOT_W'(8192)) >>> 14);
  assign samp_done = (samp_r + CNT_W'(1)) == n_r;

  // ---------------------------------------------------------------- operand stage
  assign acc_sel = (c_v_r && c_kind_r == K_ACC) ? c_idx_r[JW-1:0] : fj_r;
  assign acc_rd  = acc_r[acc_sel];
  assign acc_pad = PAD_W'(acc_rd);
  assign limb    = acc_pad[b_idx_r * sh_ctp_pkg::LIMB_W +: sh_ctp_pkg::LIMB_W];

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (b_kind_r)
      K_DOT: begin
        case (b_idx_r)
          TAG_W'(0): begin
            mul_a = sh_ctp_pkg::MUL_AW'($signed(dir_r[3*VW-1:2*VW]));
            mul_b = sh_ctp_pkg::MUL_BW'(nx_r);
          end
          TAG_W'(1): begin
            mul_a = sh_ctp_pkg::MUL_AW'($signed(dir_r[2*VW-1:VW]));
            mul_b = sh_ctp_pkg::MUL_BW'(ny_r);
          end
          default: begin
            mul_a = sh_ctp_pkg::MUL_AW'($signed(dir_r[VW-1:0]));
            mul_b = sh_ctp_pkg::MUL_BW'(nz_r);
          end
        endcase
      end
      K_ACC: begin
        mul_a = $signed({1'b0, h_r});
        mul_b = sh_ctp_pkg::MUL_BW'(coef_r);
      end
      K_FIN: begin
        // The top limb carries the sign; lower limbs are plain magnitudes.
        if (b_idx_r == TAG_W'(LIMBS - 1)) begin
          mul_a = $signed({limb[sh_ctp_pkg::LIMB_W-1], limb});
        end else begin
          mul_a = $signed({1'b0, limb});
        end
        mul_b = $signed({1'b0, wgt_r});
      end
      default: ;
    endcase
  end

  // ---------------------------------------------------------------- result of scaling
  assign fin_sh = (fin_r + RND) >>> 34;

  always_comb begin
    if (fin_sh > SAT_HI) begin
      sat_val = sh_ctp_pkg::RES_W'(SAT_HI);
    end else if (fin_sh < SAT_LO) begin
      sat_val = sh_ctp_pkg::RES_W'(SAT_LO);
    end else begin
      sat_val = sh_ctp_pkg::RES_W'(fin_sh);
    end
  end

  // ---------------------------------------------------------------- datapath registers
  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
    if (in_fire && in_ch.command == sh_ctp_pkg::CMD_COMPUTE) begin
      for (int i = 0; i < NUM_COEFFS; i++) begin
        acc_r[i] <= '0;
      end
    end else if (c_v_r) begin
      case (c_kind_r)
        K_DOT: begin
          if (c_idx_r == '0) begin
            dot_r <= DOT_W'(prod_r);
          end else begin
            dot_r <= dot_r + DOT_W'(prod_r);
          end
        end
        K_ACC: acc_r[c_idx_r[JW-1:0]] <= acc_rd + ACC_W'(prod_r);
        K_FIN: begin
          // Partial products arrive from the top limb down.
          if (c_idx_r == TAG_W'(LIMBS - 1)) begin
            fin_r <= FIN_W'(prod_r);
          end else begin
            fin_r <= (fin_r <<< sh_ctp_pkg::LIMB_W) + FIN_W'(prod_r);
          end
        end
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      b_v_r       <= 1'b0;
      c_v_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      b_v_r    <= iss_v;
      b_kind_r <= iss_kind;
      b_idx_r  <= iss_idx;
      c_v_r    <= b_v_r;
      c_kind_r <= b_kind_r;
      c_idx_r  <= b_idx_r;

      if (state_r == ST_FOUT && pipe_empty && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        ST_IDLE: begin
          if (in_fire && in_ch.command == sh_ctp_pkg::CMD_COMPUTE) begin
            nx_r   <= in_ch.normal_x;
            ny_r   <= in_ch.normal_y;
            nz_r   <= in_ch.normal_z;
            n_r    <= n_new;
            samp_r <= '0;
            ca_r   <= '0;
            k_r    <= 2'd0;
            fj_r   <= '0;
            state_r <= (n_new == '0) ? ST_DRAIN : ST_DOT;
          end
        end
        ST_DOT: begin
          k_r <= k_r + 2'd1;
          if (k_r == 2'd2) begin
            state_r <= ST_DOTW;
          end
        end
        ST_DOTW: begin
          if (pipe_empty) begin
            k_r <= 2'd0;
            if (dot_pos) begin
              h_r     <= h_new;
              j_r     <= '0;
              state_r <= ST_MAC;
            end else begin
              ca_r   <= ca_r + COEF_AW'(NUM_COEFFS);
              samp_r <= samp_r + CNT_W'(1);
              state_r <= samp_done ? ST_DRAIN : ST_DOT;
            end
          end
        end
        ST_MAC: begin
          ca_r <= ca_r + COEF_AW'(1);
          j_r  <= j_r + JW'(1);
          if (j_r == JW'(NUM_COEFFS - 1)) begin
            samp_r  <= samp_r + CNT_W'(1);
            state_r <= samp_done ? ST_DRAIN : ST_DOT;
          end
        end
        ST_DRAIN: begin
          if (pipe_empty) begin
            l_r     <= TAG_W'(LIMBS - 1);
            state_r <= ST_FIN;
          end
        end
        ST_FIN: begin
          l_r <= l_r - TAG_W'(1);
          if (l_r == '0) begin
            state_r <= ST_FOUT;
          end
        end
        ST_FOUT: begin
          if (pipe_empty && out_free) begin
            out_index_r <= sh_ctp_pkg::RIDX_W'(fj_r);
            out_value_r <= sat_val;
            out_last_r  <= (fj_r == JW'(NUM_COEFFS - 1));
            if (fj_r == JW'(NUM_COEFFS - 1)) begin
              state_r <= ST_IDLE;
            end else begin
              fj_r    <= fj_r + JW'(1);
              l_r     <= TAG_W'(LIMBS - 1);
              state_r <= ST_FIN;
            end
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.result_index   = out_index_r;
  assign out_ch.transfer_value = out_value_r;
  assign out_ch.last           = out_last_r;

endmodule
